// ===== src/tdp_pkg.sv =====
// Shared types and constants for the table delta audio decoder.
package tdp_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TABLE_DEPTH  = 256;
    localparam int CODE_W       = 8;
    localparam int SAMPLE_W     = 16;

    localparam logic signed [SAMPLE_W:0] SAT_MAX = 17'sd32767;
    localparam logic signed [SAMPLE_W:0] SAT_MIN = -17'sd32767;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic
    {
        OP_DECODE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } result_t;

endpackage

// ===== src/tdp_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module tdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== src/table_delta_audio_decoder.sv =====
// Top level: table-driven delta decoder for interleaved multichannel audio.
// The table RAM read and the saturating accumulator add take one stage each:
// a decode word's entry is registered by the read, its sum by the two-entry
// output buffer, which holds stalls. One word per cycle while s_tready is high.
// Reset clears the accumulators, the channel pointer and the pipeline at once;
// the delta table holds no defined value until loaded.
module table_delta_audio_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // code[7:0], table_value[23:8]
    input  logic        s_tuser,   // op
    input  logic        s_tlast,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample[15:0]
    output logic        m_tuser    // channel
);

    import tdp_pkg::*;

    logic                        accept;
    logic                        is_decode;
    logic [CODE_W-1:0]           code;
    logic [SAMPLE_W-1:0]         table_value;
    logic [SAMPLE_W-1:0]         delta;

    logic [CH_W-1:0]             cur_ch_reg, cur_ch_next;
    logic [CH_W-1:0]             in_ch;
    logic                        s1_valid_reg;
    logic [CH_W-1:0]             s1_ch_reg;

    logic signed [SAMPLE_W-1:0]  acc_reg [NUM_CHANNELS];
    logic signed [SAMPLE_W:0]    sum;
    logic signed [SAMPLE_W-1:0]  sat;
    result_t                     s1_res;

    result_t                     out_reg, out_next, skid_reg, skid_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        skid_valid_reg, skid_valid_next;
    logic                        pop;

    assign code        = s_tdata[CODE_W-1:0];
    assign table_value = s_tdata[CODE_W +: SAMPLE_W];
    assign accept      = s_tvalid && s_tready;
    assign is_decode   = (op_t'(s_tuser) == OP_DECODE);
    assign pop         = out_valid_reg && m_tready;

    // Block only when a result in flight would find both buffer slots taken.
    assign s_tready = !skid_valid_reg && !(s1_valid_reg && out_valid_reg && !m_tready);

    tdp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (accept),
        .we    (op_t'(s_tuser) == OP_LOAD),
        .addr  (code),
        .wdata (table_value),
        .rdata (delta)
    );

    // Channel pointer advances at acceptance of a decode word.
    always_comb
    begin
        in_ch       = s_tlast ? '0 : cur_ch_reg;
        cur_ch_next = cur_ch_reg;
        if (accept && is_decode)
        begin
            cur_ch_next = (in_ch == LAST_CH) ? '0 : in_ch + CH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cur_ch_reg   <= cur_ch_next;
            s1_valid_reg <= accept && is_decode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg <= in_ch;
        end
    end

    // Saturating accumulate against the entry just read.
    always_comb
    begin
        sum = (SAMPLE_W+1)'(acc_reg[s1_ch_reg]) + (SAMPLE_W+1)'($signed(delta));
        if (sum > SAT_MAX)
        begin
            sat = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            sat = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sat = sum[SAMPLE_W-1:0];
        end
        s1_res.sample  = sat;
        s1_res.channel = s1_ch_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            acc_reg[s1_ch_reg] <= sat;
        end
    end

    // Output register plus skid entry, oldest word in out_reg.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !pop)
        begin
            if (s1_valid_reg)
            begin
                skid_next       = s1_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_next       = s1_res;
            skid_valid_next = s1_valid_reg;
        end
        else
        begin
            out_next        = s1_res;
            out_valid_next  = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sample;
    assign m_tuser  = out_reg.channel;

endmodule

// ===== sim/tb_table_delta_audio_decoder.sv =====
// Testbench for the table delta audio decoder: scoreboard-checked directed and random streams.
`timescale 1ns / 1ps

module tb_table_delta_audio_decoder;

    import tdp_pkg::*;

    localparam int SAMPLE_LATENCY = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 400;
    localparam int MAX_REPORTS    = 10;

    // Tracks table contents, per-channel accumulators and the channel pointer,
    // and keeps the queue of samples the block still owes.
    class decode_scoreboard;
        logic signed [SAMPLE_W-1:0] delta_mem [TABLE_DEPTH];
        logic signed [SAMPLE_W-1:0] acc [NUM_CHANNELS];
        int                         next_ch;
        result_t                    expected_q [$];
        int                         errors;
        int                         loads;
        int                         decodes;
        int                         frame_marks;
        int                         sat_high;
        int                         sat_low;

        function new();
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                acc[i] = '0;
            end
            next_ch     = 0;
            errors      = 0;
            loads       = 0;
            decodes     = 0;
            frame_marks = 0;
            sat_high    = 0;
            sat_low     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(op_t op, logic [CODE_W-1:0] code,
                                logic signed [SAMPLE_W-1:0] value, logic fs);
            logic signed [SAMPLE_W:0] sum;
            int                       ch;
            result_t                  res;
            if (op == OP_LOAD)
            begin
                delta_mem[code] = value;
                loads++;
                return;
            end
            if (fs)
            begin
                next_ch = 0;
                frame_marks++;
            end
            ch = (next_ch >= NUM_CHANNELS) ? 0 : next_ch;
            sum = acc[ch] + delta_mem[code];
            if (sum > SAT_MAX)
            begin
                sum = SAT_MAX;
                sat_high++;
            end
            if (sum < SAT_MIN)
            begin
                sum = SAT_MIN;
                sat_low++;
            end
            acc[ch]     = sum[SAMPLE_W-1:0];
            res.sample  = sum[SAMPLE_W-1:0];
            res.channel = ch[0];
            expected_q.push_back(res);
            decodes++;
            next_ch = (ch + 1 >= NUM_CHANNELS) ? 0 : ch + 1;
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic channel);
            result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected sample %0d ch %0d", sample, channel);
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.sample !== sample || exp_res.channel !== channel)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: sample exp %0d ch %0d, got %0d ch %0d",
                             exp_res.sample, exp_res.channel, sample, channel);
            end
        endfunction

        function void check_drained();
            if (expected_q.size() != 0)
            begin
                errors += expected_q.size();
                $display("ERROR: %0d samples never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // code[7:0], table_value[23:8]
    logic        s_tuser;   // op
    logic        s_tlast;   // frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // sample[15:0]
    logic        m_tuser;   // channel

    decode_scoreboard    sb;
    int                  src_idle_pct;
    int                  sink_stall_pct;
    bit                  hold_req;
    logic [CODE_W-1:0]   written_codes [$];
    bit                  written_flag [TABLE_DEPTH];

    table_delta_audio_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off counted here on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(op_t'(s_tuser), s_tdata[7:0], s_tdata[23:8], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_sample(m_tdata, m_tuser);
        end
    end

    task automatic send_word(input op_t op, input logic [CODE_W-1:0] code,
                             input logic signed [SAMPLE_W-1:0] value, input logic fs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, code};
        s_tuser  <= op;
        s_tlast  <= fs;
        if (op == OP_LOAD && !written_flag[code])
        begin
            written_flag[code] = 1'b1;
            written_codes.push_back(code);
        end
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering and wait until every owed sample has been taken.
    task automatic wait_samples_out();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] val;
        logic [CODE_W-1:0]          code;
        sb             = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_DECODE;
        s_tlast  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: table extremes, saturation both ways, frame marks.
        send_word(OP_LOAD,   8'h00,  16'sd32767, 1'b1);  // frame mark on load is ignored
        send_word(OP_LOAD,   8'hFF, -16'sd32768, 1'b0);
        send_word(OP_LOAD,   8'h01,  16'sd0,     1'b0);
        send_word(OP_LOAD,   8'h80, -16'sd1,     1'b0);
        send_word(OP_LOAD,   8'h7F,  16'sd1,     1'b0);
        send_word(OP_DECODE, 8'h00,  16'sd0,     1'b1);
        send_word(OP_DECODE, 8'h00,  16'sd0,     1'b0);
        send_word(OP_DECODE, 8'h00,  16'sd0,     1'b0);  // clips high
        send_word(OP_DECODE, 8'hFF,  16'sd0,     1'b1);
        send_word(OP_DECODE, 8'hFF,  16'sd0,     1'b0);
        send_word(OP_DECODE, 8'hFF,  16'sd0,     1'b0);  // clips low
        send_word(OP_DECODE, 8'hFF,  16'sd0,     1'b0);
        send_word(OP_DECODE, 8'hFF,  16'sd0,     1'b0);
        send_word(OP_DECODE, 8'h80,  16'sd0,     1'b1);  // sum of -32768 clips to -32767
        send_word(OP_LOAD,   8'h55,  16'sh5555,  1'b1);
        send_word(OP_DECODE, 8'h55,  16'sd0,     1'b0);  // stays on right channel
        send_word(OP_DECODE, 8'h7F,  16'sd0,     1'b1);
        send_word(OP_DECODE, 8'h01,  16'sd0,     1'b1);
        send_word(OP_DECODE, 8'h01,  16'sd0,     1'b0);
        send_word(OP_LOAD,   8'hAA, -16'sd21846, 1'b0);
        send_word(OP_DECODE, 8'hAA,  16'sh7FFF,  1'b0);
        wait_samples_out();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            if (phase == 0)
                hold_req = 1'b1;  // sender keeps pushing into a blocked output
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                case ($urandom_range(9))
                    0:       val = 16'sd32767;
                    1:       val = -16'sd32768;
                    2, 3, 4: val = SAMPLE_W'(int'($urandom_range(511)) - 256);
                    default: val = SAMPLE_W'($urandom);
                endcase
                if ($urandom_range(99) < 25)
                    send_word(OP_LOAD, CODE_W'($urandom), val, 1'($urandom_range(1)));
                else
                begin
                    code = written_codes[$urandom_range(written_codes.size() - 1)];
                    send_word(OP_DECODE, code, val, ($urandom_range(7) == 0));
                end
                if (phase == 2 && i == PHASE_WORDS / 2)
                    wait_samples_out();
            end
            wait_samples_out();
        end

        repeat (SAMPLE_LATENCY + 8) @(posedge clk);
        sb.check_drained();
        $display("covered %0d table writes and %0d decoded samples, %0d with frame mark",
                 sb.loads, sb.decodes, sb.frame_marks);
        $display("clipped high %0d times, low %0d times, over four idle/stall mixes",
                 sb.sat_high, sb.sat_low);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tdp_pkg.sv
src/tdp_ram.sv
src/table_delta_audio_decoder.sv
sim/tb_table_delta_audio_decoder.sv
